// ----- rtl/core/rteq_pkg.sv -----
// shared constants and types for the relative time event queue
// no dependencies
package rteq_pkg;
  localparam int QueueDepth = 16;
  localparam int TimeBits   = 48;
  localparam int IdxBits    = $clog2(QueueDepth);
  localparam int CntBits    = $clog2(QueueDepth + 1);
  localparam int SpeedBits  = 32;
  localparam int TagBits    = 8;
  localparam int OccBits    = 5;
  localparam int DivBits    = TimeBits + SpeedBits;

  localparam logic [1:0] ACT_ADD     = 2'd0;
  localparam logic [1:0] ACT_NEXT    = 2'd1;
  localparam logic [1:0] ACT_RESCALE = 2'd2;
  localparam logic [1:0] ACT_LIST    = 2'd3;

  localparam logic [TimeBits-1:0] TimeMax = {TimeBits{1'b1}};

  typedef logic [TimeBits-1:0] time_t;

  // broadcast command from the controller to every cell
  typedef struct packed {
    logic  ins;        // sorted insert
    logic  pop;        // shift left by one
    logic  adv;        // subtract and accumulate
    logic  shl;        // rotate left (rescale / list walk)
    logic  ld_scaled;  // last cell takes scaled value on rotate
    time_t ins_time;
    logic [TagBits-1:0] ins_tag;
    time_t adv_time;
    time_t scaled;
  } rteq_cmd_t;

  typedef struct packed {
    time_t dly;
    time_t acc;
    logic [TagBits-1:0] tag;
  } rteq_entry_t;

  function automatic time_t sat_add(time_t a, time_t b);
    logic [TimeBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeBits] ? TimeMax : s[TimeBits-1:0];
  endfunction
endpackage

// ----- rtl/core/rteq_cell.sv -----
// one queue slot: holds an entry and trades it with its neighbors
// depends on rteq_pkg
module rteq_cell
  import rteq_pkg::*;
(
  input  logic        clk,
  input  rteq_cmd_t   cmd,
  input  logic        occ,        // this slot holds an entry
  input  logic        left_gt,    // left neighbor's delay is >= new time
  input  logic        left_occ,
  input  rteq_entry_t left_ent,
  input  rteq_entry_t right_ent,
  input  logic        is_last,
  output rteq_entry_t ent,
  output logic        ge_new      // this entry moves right on insert
);
  rteq_entry_t ent_r, ent_nxt;
  assign ent = ent_r;
  assign ge_new = occ && (ent_r.dly >= cmd.ins_time);

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.ins) begin
      if (ge_new || !occ) begin
        if (left_occ && left_gt) ent_nxt = left_ent;
        else if (!left_occ || !left_gt) begin
          if (occ || (left_occ || is_last || !left_occ))
            ent_nxt = '{dly: cmd.ins_time, acc: '0, tag: cmd.ins_tag};
        end
      end
    end else if (cmd.pop) begin
      ent_nxt = right_ent;
    end else if (cmd.shl) begin
      ent_nxt = right_ent;
      if (is_last && cmd.ld_scaled) ent_nxt.dly = cmd.scaled;
    end
    if (cmd.adv) begin
      ent_nxt.dly = (ent_nxt.dly >= cmd.adv_time) ? ent_nxt.dly - cmd.adv_time : '0;
      ent_nxt.acc = sat_add(ent_nxt.acc, cmd.adv_time);
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end
endmodule

// ----- rtl/core/rteq_div.sv -----
// bit-serial scaler: t * num / den, saturating to the time width
// depends on rteq_pkg
module rteq_div
  import rteq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  time_t                t,
  input  logic [SpeedBits-1:0] num,
  input  logic [SpeedBits-1:0] den,
  output logic                 done,
  output time_t                q
);
  localparam int StepBits = $clog2(DivBits + 1);
  logic                   busy_r, busy_nxt;
  logic                   mul_r, mul_nxt;
  logic                   hi_r, hi_nxt;      // upper partial product still to add
  logic [StepBits-1:0]    cnt_r, cnt_nxt;
  logic [DivBits-1:0]     prod_r, prod_nxt;
  logic [SpeedBits:0]     rem_r, rem_nxt;
  logic [DivBits-1:0]     quo_r, quo_nxt;
  logic [SpeedBits:0]     trial;
  logic                   done_r, done_nxt;
  logic [SpeedBits-1:0]   mul_a;
  logic [2*SpeedBits-1:0] mprod;

  assign done = done_r;
  assign q = (|quo_r[DivBits-1:TimeBits]) ? TimeMax : quo_r[TimeBits-1:0];
  assign trial = {rem_r[SpeedBits-1:0], prod_r[DivBits-1]} - {1'b0, den};
  assign mul_a = hi_r ? SpeedBits'(t[TimeBits-1:SpeedBits]) : t[SpeedBits-1:0];
  assign mprod = mul_a * num;

  always_comb begin
    busy_nxt = busy_r; mul_nxt = mul_r; hi_nxt = hi_r; cnt_nxt = cnt_r;
    prod_nxt = prod_r; rem_nxt = rem_r; quo_nxt = quo_r; done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1; mul_nxt = 1'b1; hi_nxt = 1'b0; cnt_nxt = '0;
      prod_nxt = '0; rem_nxt = '0;
    end else if (busy_r && mul_r && !hi_r) begin
      // low partial product, 32x32
      prod_nxt = DivBits'(mprod);
      hi_nxt = 1'b1;
    end else if (busy_r && mul_r) begin
      // high partial product, added starting at bit 32
      prod_nxt = prod_r + {mprod[DivBits-SpeedBits-1:0], {SpeedBits{1'b0}}};
      mul_nxt = 1'b0; hi_nxt = 1'b0;
    end else if (busy_r) begin
      // restoring division, one quotient bit per cycle
      if (!trial[SpeedBits] || rem_r[SpeedBits-1]) begin
        rem_nxt = {1'b0, trial[SpeedBits-1:0]};
        quo_nxt = {quo_r[DivBits-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[SpeedBits-1:0], prod_r[DivBits-1]};
        quo_nxt = {quo_r[DivBits-2:0], 1'b0};
      end
      prod_nxt = {prod_r[DivBits-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == StepBits'(DivBits - 1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; mul_r <= 1'b0; hi_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; mul_r <= mul_nxt; hi_r <= hi_nxt;
    end
    cnt_r <= cnt_nxt; prod_r <= prod_nxt; rem_r <= rem_nxt; quo_r <= quo_nxt;
  end
endmodule

// ----- rtl/core/relative_time_event_queue.sv -----
// top level of the relative time event queue: controller, row of cells, scaler
// depends on rteq_pkg, rteq_cell, rteq_div
//
//  channel | direction | handshake          | payload
//  in_     | request   | in_valid/in_ready  | action, delay_in, event_tag, new_speed
//  out_    | result    | out_valid/out_ready| ok, passed_time, total_time, tags, occupancy, last
//  cfg_    | write     | cfg_valid/cfg_ready| start_speed
//
// add and next: result registered at the accepting edge, one request per cycle while out_ready is high
// rescale: per queued entry, a product from low and high partial products, then 80 quotient bits
// list: the list state registers the first tag after the request, then one result per cycle with out_ready high
// synchronous active-low reset; queue contents are not cleared, only the count
// a request is taken only when the block is idle and the result register is free
module relative_time_event_queue
  import rteq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  input  logic [TimeBits-1:0]  in_delay_in,
  input  logic [TagBits-1:0]   in_event_tag,
  input  logic [SpeedBits-1:0] in_new_speed,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_ok,
  output logic [TimeBits-1:0]  out_passed_time,
  output logic [TimeBits-1:0]  out_total_time,
  output logic [TagBits-1:0]   out_current_tag,
  output logic [OccBits-1:0]   out_occupancy,
  output logic [TagBits-1:0]   out_listed_tag,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [SpeedBits-1:0] cfg_start_speed
);
  // controller states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RSTRT = 3'd1;  // launch scaler on head
  localparam logic [2:0] ST_RWAIT = 3'd2;  // wait for scaler, rotate
  localparam logic [2:0] ST_LIST  = 3'd3;  // walk row emitting tags
  localparam logic [2:0] ST_RDONE = 3'd4;  // rescale finished

  logic [2:0]           st_r, st_nxt;
  logic [CntBits-1:0]   cnt_r, cnt_nxt;
  logic [CntBits-1:0]   walk_r, walk_nxt;   // entries left to process
  logic                 arr_pend_r, arr_pend_nxt;
  time_t                arr_dly_r, arr_dly_nxt;
  time_t                lpass_r, lpass_nxt;
  time_t                ltot_r, ltot_nxt;
  logic [TagBits-1:0]   ltag_r, ltag_nxt;
  logic [SpeedBits-1:0] speed_r, speed_nxt;
  logic [SpeedBits-1:0] nspeed_r, nspeed_nxt;
  logic                 first_r, first_nxt; // list: current tag still to emit

  logic                 ov_r, ov_nxt;
  logic                 ook_r, ook_nxt, olast_r, olast_nxt;
  logic [TagBits-1:0]   olt_r, olt_nxt;

  rteq_cmd_t            cmd;
  rteq_entry_t          ents [QueueDepth];
  logic                 ge   [QueueDepth];
  logic                 occv [QueueDepth];
  rteq_entry_t          zero_ent;

  logic                 div_start, div_done;
  time_t                div_q;
  logic                 out_free, acc_in;

  assign zero_ent = '0;
  assign out_free = !ov_r || out_ready;
  assign in_ready = (st_r == ST_IDLE) && out_free;
  assign acc_in   = in_valid && in_ready;
  assign cfg_ready = (st_r == ST_IDLE);

  // row of cells, entry 0 is the head; the tail cell sees the head on its right
  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    assign occv[i] = (CntBits'(i) < cnt_r);
    rteq_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .occ      (occv[i]),
      .left_gt  ((i == 0) ? 1'b0 : ge[(i == 0) ? 0 : i-1]),
      .left_occ ((i == 0) ? 1'b0 : occv[(i == 0) ? 0 : i-1]),
      .left_ent ((i == 0) ? zero_ent : ents[(i == 0) ? 0 : i-1]),
      .right_ent((i == QueueDepth-1 || CntBits'(i + 1) == cnt_r) ? ents[0] :
                 ents[(i == QueueDepth-1) ? 0 : i+1]),
      .is_last  (CntBits'(i + 1) == cnt_r),
      .ent      (ents[i]),
      .ge_new   (ge[i])
    );
  end

  rteq_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .t(ents[0].dly),
    .num(speed_r), .den(nspeed_r), .done(div_done), .q(div_q)
  );

  logic from_head;
  time_t pop_t;
  logic [OccBits-1:0] occ_now;
  assign occ_now = OccBits'(cnt_r) + OccBits'(ltag_r != '0);

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; walk_nxt = walk_r;
    arr_pend_nxt = arr_pend_r; arr_dly_nxt = arr_dly_r;
    lpass_nxt = lpass_r; ltot_nxt = ltot_r; ltag_nxt = ltag_r;
    speed_nxt = speed_r; nspeed_nxt = nspeed_r; first_nxt = first_r;
    ov_nxt = ov_r && !out_ready; ook_nxt = ook_r; olast_nxt = olast_r; olt_nxt = olt_r;
    cmd = '0; cmd.ins_time = in_delay_in; cmd.ins_tag = in_event_tag;
    cmd.scaled = div_q;
    div_start = 1'b0;
    from_head = (cnt_r != '0) && !(arr_pend_r && ents[0].dly > arr_dly_r);
    pop_t = from_head ? ents[0].dly : arr_dly_r;
    cmd.adv_time = pop_t;

    if (cfg_valid && cfg_ready) speed_nxt = cfg_start_speed;

    unique case (st_r)
      ST_IDLE: begin
        if (acc_in) begin
          ov_nxt = 1'b1; olast_nxt = 1'b1; olt_nxt = '0; ook_nxt = 1'b1;
          unique case (in_action)
            ACT_ADD: begin
              if (in_event_tag == '0) begin
                arr_dly_nxt = in_delay_in; arr_pend_nxt = 1'b1;
              end else if (cnt_r >= CntBits'(QueueDepth)) begin
                ook_nxt = 1'b0;
              end else begin
                cmd.ins = 1'b1; cnt_nxt = cnt_r + 1'b1;
              end
            end
            ACT_NEXT: begin
              if (cnt_r == '0 && !arr_pend_r) begin
                ook_nxt = 1'b0;
              end else if (from_head) begin
                lpass_nxt = pop_t; ltot_nxt = sat_add(ents[0].acc, pop_t);
                ltag_nxt = ents[0].tag;
                cmd.pop = 1'b1; cmd.adv = 1'b1; cnt_nxt = cnt_r - 1'b1;
                if (arr_pend_r) arr_dly_nxt = (arr_dly_r >= pop_t) ? arr_dly_r - pop_t : '0;
              end else begin
                lpass_nxt = pop_t; ltot_nxt = '0; ltag_nxt = '0;
                arr_pend_nxt = 1'b0; arr_dly_nxt = '0; cmd.adv = 1'b1;
              end
            end
            ACT_RESCALE: begin
              if (in_new_speed == '0) ook_nxt = 1'b0;
              else begin
                ov_nxt = 1'b0; nspeed_nxt = in_new_speed; walk_nxt = cnt_r;
                st_nxt = (cnt_r == '0) ? ST_RDONE : ST_RSTRT;
              end
            end
            ACT_LIST: begin
              if (occ_now == '0) ook_nxt = 1'b0;
              else begin
                ov_nxt = 1'b0; walk_nxt = cnt_r; first_nxt = (ltag_r != '0);
                st_nxt = ST_LIST;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RSTRT: begin
        div_start = 1'b1; st_nxt = ST_RWAIT;
      end
      ST_RWAIT: begin
        if (div_done) begin
          // rotate: head goes to the tail carrying its scaled delay
          cmd.shl = 1'b1; cmd.ld_scaled = 1'b1;
          walk_nxt = walk_r - 1'b1;
          st_nxt = (walk_r == CntBits'(1)) ? ST_RDONE : ST_RSTRT;
        end
      end
      ST_RDONE: begin
        if (out_free) begin
          speed_nxt = nspeed_r;
          ov_nxt = 1'b1; ook_nxt = 1'b1; olt_nxt = '0; olast_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      ST_LIST: begin
        if (out_free) begin
          ov_nxt = 1'b1; ook_nxt = 1'b1;
          if (first_r) begin
            olt_nxt = ltag_r; first_nxt = 1'b0;
            olast_nxt = (walk_r == '0);
            if (walk_r == '0) st_nxt = ST_IDLE;
          end else begin
            // emit head, rotate so the row returns to order at the end
            olt_nxt = ents[0].tag; cmd.shl = 1'b1;
            walk_nxt = walk_r - 1'b1;
            olast_nxt = (walk_r == CntBits'(1));
            if (walk_r == CntBits'(1)) st_nxt = ST_IDLE;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; cnt_r <= '0; arr_pend_r <= 1'b0; arr_dly_r <= '0;
      lpass_r <= '0; ltot_r <= '0; ltag_r <= '0; ov_r <= 1'b0;
      speed_r <= SpeedBits'(65536); first_r <= 1'b0; walk_r <= '0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; arr_pend_r <= arr_pend_nxt;
      arr_dly_r <= arr_dly_nxt; lpass_r <= lpass_nxt; ltot_r <= ltot_nxt;
      ltag_r <= ltag_nxt; ov_r <= ov_nxt; speed_r <= speed_nxt;
      first_r <= first_nxt; walk_r <= walk_nxt;
    end
    nspeed_r <= nspeed_nxt; ook_r <= ook_nxt; olast_r <= olast_nxt; olt_r <= olt_nxt;
  end

  // status fields follow the state registers, which are written at the same edge that raises out_valid
  assign out_valid       = ov_r;
  assign out_ok          = ook_r;
  assign out_passed_time = lpass_r;
  assign out_total_time  = ltot_r;
  assign out_current_tag = ltag_r;
  assign out_occupancy   = occ_now;
  assign out_listed_tag  = olt_r;
  assign out_last        = olast_r;

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntBits'(QueueDepth)) else $error("queue count overflow");
  a_busy_noin: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> !in_ready) else $error("request taken while busy");
  a_add_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_in && in_action == ACT_ADD && in_event_tag != '0 && cnt_r < CntBits'(QueueDepth))
    |=> cnt_r == $past(cnt_r) + 1'b1) else $error("insert lost");
`endif
endmodule
